FILE: rtl/cpyp_pkg.sv
package cpyp_pkg;

	// Guard fraction bits added below the input LSB before the rotations.
	localparam int GUARD_BITS = 16;

	// Rotation datapath widths: yaw works on longitude and latitude differences,
	// pitch on the altitude difference against the horizontal magnitude.
	localparam int XW_YAW   = 52;
	localparam int XW_PITCH = 60;

	// Angle accumulator: degrees with 32 fraction bits, room for +-512 degrees.
	localparam int ZW = 42;

	localparam int          RAD_FRAC        = 36;
	localparam longint      DEG_PER_RAD_Q22 = 64'sd240315917;
	localparam int          GAIN_W          = 30;
	localparam logic [29:0] GAIN_Q30        = 30'd652032874;

	localparam logic signed [ZW-1:0] Z_PLUS_90  = ZW'(longint'(90) <<< 32);
	localparam logic signed [ZW-1:0] Z_MINUS_90 = ZW'(-(longint'(90) <<< 32));

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	// Shift-and-subtract quotient, used only while the angle table is built.
	function automatic longint div_small(input longint num, input longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 39; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			if (r >= den) begin
				r = r - den;
				q = q | (longint'(1) <<< b);
			end
		end
		return q;
	endfunction

	// Elementary angle atan(2^-i) in degrees with 32 fraction bits.
	function automatic longint elem_angle(input int unsigned i);
		longint      rad;
		longint      term;
		int unsigned e;
		rad = 0;
		if (i == 0) begin
			return longint'(45) <<< 32;
		end
		for (int unsigned k = 0; k < 19; k++) begin
			e = i * (2 * k + 1);
			if (e <= RAD_FRAC) begin
				term = div_small(longint'(1) <<< (RAD_FRAC - e), longint'(2 * k + 1));
				if (k[0]) begin
					rad = rad - term;
				end else begin
					rad = rad + term;
				end
			end
		end
		return (rad * DEG_PER_RAD_Q22 + (longint'(1) <<< 25)) >>> 26;
	endfunction

endpackage

FILE: rtl/cpyp_cordic_cell.sv
module cpyp_cordic_cell #(
	parameter int XW = 52,
	parameter int SHIFT = 0,
	parameter logic signed [cpyp_pkg::ZW-1:0] ANGLE = '0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpyp_pkg::ctl_t                 ctl_i,
	input  logic signed [XW-1:0]           x_i,
	input  logic signed [XW-1:0]           y_i,
	input  logic signed [cpyp_pkg::ZW-1:0] z_i,
	output cpyp_pkg::ctl_t                 ctl_o,
	output logic signed [XW-1:0]           x_o,
	output logic signed [XW-1:0]           y_o,
	output logic signed [cpyp_pkg::ZW-1:0] z_o
);
	import cpyp_pkg::*;

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_d;
	logic signed [XW-1:0] y_d;
	logic signed [ZW-1:0] z_d;
	ctl_t                 ctl_s1;
	logic signed [XW-1:0] x_s1;
	logic signed [XW-1:0] y_s1;
	logic signed [ZW-1:0] z_s1;

	always_comb begin
		xs = x_i >>> SHIFT;
		ys = y_i >>> SHIFT;
		// Rotate towards the x axis: the sign of y picks the direction.
		if (!y_i[XW-1]) begin
			x_d = x_i + ys;
			y_d = y_i - xs;
			z_d = z_i + ANGLE;
		end else begin
			x_d = x_i - ys;
			y_d = y_i + xs;
			z_d = z_i - ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_d;
		y_s1 <= y_d;
		z_s1 <= z_d;
	end

	assign ctl_o = ctl_s1;
	assign x_o   = x_s1;
	assign y_o   = y_s1;
	assign z_o   = z_s1;

endmodule

FILE: rtl/cpyp_cordic_chain.sv
module cpyp_cordic_chain #(
	parameter int CORDIC_STAGES = 24,
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int XW = 52,
	parameter int SIDE_W = 41,
	parameter int LIMIT_DEG = 180,
	parameter int OUT_W = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [XW-1:0]    x_in,
	input  logic signed [XW-1:0]    y_in,
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    out_valid,
	output logic signed [OUT_W-1:0] angle,
	output logic signed [XW-1:0]    raw_x,
	output logic [SIDE_W-1:0]       side_out
);
	import cpyp_pkg::*;

	localparam int SH = 32 - ANGLE_FRAC_BITS;
	localparam logic signed [ZW:0] HALF = (ZW + 1)'(longint'(1) <<< (SH - 1));
	localparam logic signed [ZW:0] LIM  = (ZW + 1)'(longint'(LIMIT_DEG) <<< ANGLE_FRAC_BITS);

	ctl_t                 ctl_c  [CORDIC_STAGES+1];
	logic signed [XW-1:0] x_c    [CORDIC_STAGES+1];
	logic signed [XW-1:0] y_c    [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_c    [CORDIC_STAGES+1];
	logic [SIDE_W-1:0]    side_c [CORDIC_STAGES+1];

	logic signed [XW-1:0] x_pre;
	logic signed [XW-1:0] y_pre;
	logic signed [ZW-1:0] z_pre;
	ctl_t                 ctl_pre;
	ctl_t                 ctl_s1;
	logic signed [XW-1:0] x_s1;
	logic signed [XW-1:0] y_s1;
	logic signed [ZW-1:0] z_s1;
	logic [SIDE_W-1:0]    side_s1;

	logic signed [ZW:0]      z_sum;
	logic signed [ZW:0]      z_rnd;
	logic signed [ZW:0]      z_sat;
	logic                    valid_s3;
	logic signed [OUT_W-1:0] angle_s3;
	logic signed [XW-1:0]    x_s3;
	logic [SIDE_W-1:0]       side_s3;

	// A vector in the left half-plane is first turned by a quarter turn so that
	// the rotations start with x non-negative.
	always_comb begin
		ctl_pre.valid = in_valid;
		ctl_pre.zero  = (x_in == '0) && (y_in == '0);
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in[XW-1]) begin
			if (!y_in[XW-1]) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = Z_PLUS_90;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = Z_MINUS_90;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_pre;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_pre;
		y_s1    <= y_pre;
		z_s1    <= z_pre;
		side_s1 <= side_in;
	end

	assign ctl_c[0]  = ctl_s1;
	assign x_c[0]    = x_s1;
	assign y_c[0]    = y_s1;
	assign z_c[0]    = z_s1;
	assign side_c[0] = side_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		cpyp_cordic_cell #(
			.XW    (XW),
			.SHIFT (g),
			.ANGLE (ZW'(elem_angle(g)))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[g]),
			.x_i    (x_c[g]),
			.y_i    (y_c[g]),
			.z_i    (z_c[g]),
			.ctl_o  (ctl_c[g+1]),
			.x_o    (x_c[g+1]),
			.y_o    (y_c[g+1]),
			.z_o    (z_c[g+1])
		);

		always_ff @(posedge clk) begin
			side_c[g+1] <= side_c[g];
		end
	end

	// Round half up to the output fraction, then clamp to the angle range; a zero input vector gives zero.
	always_comb begin
		z_sum = $signed({z_c[CORDIC_STAGES][ZW-1], z_c[CORDIC_STAGES]}) + HALF;
		z_rnd = z_sum >>> SH;
		if (ctl_c[CORDIC_STAGES].zero) begin
			z_sat = '0;
		end else if (z_rnd > LIM) begin
			z_sat = LIM;
		end else if (z_rnd < -LIM) begin
			z_sat = -LIM;
		end else begin
			z_sat = z_rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctl_c[CORDIC_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_s3 <= OUT_W'(z_sat);
		x_s3     <= x_c[CORDIC_STAGES];
		side_s3  <= side_c[CORDIC_STAGES];
	end

	assign out_valid = valid_s3;
	assign angle     = angle_s3;
	assign raw_x     = x_s3;
	assign side_out  = side_s3;

endmodule

FILE: rtl/cpyp_gain.sv
module cpyp_gain #(
	parameter int RW = 52,
	parameter int SIDE_W = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RW-1:0]     raw_x,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [RW-1:0]     mag,
	output logic [SIDE_W-1:0] side_out
);
	import cpyp_pkg::*;

	localparam int HI_W = RW - GAIN_W;
	localparam int PH_W = HI_W + GAIN_W;
	localparam int PL_W = 2 * GAIN_W;

	logic              valid_s1;
	logic              valid_s2;
	logic [PH_W-1:0]   p_hi_s1;
	logic [PL_W-1:0]   p_lo_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [RW-1:0]     mag_s2;
	logic [SIDE_W-1:0] side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// The magnitude is split at bit 30 so that each product stays narrow; the
	// low product is floored before the two halves are added.
	always_ff @(posedge clk) begin
		p_hi_s1 <= PH_W'(raw_x[RW-1:GAIN_W]) * PH_W'(GAIN_Q30);
		p_lo_s1 <= PL_W'(raw_x[GAIN_W-1:0]) * PL_W'(GAIN_Q30);
		side_s1 <= side_in;
		mag_s2  <= RW'(p_hi_s1) + RW'(p_lo_s1[PL_W-1:GAIN_W]);
		side_s2 <= side_s1;
	end

	assign out_valid = valid_s2;
	assign mag       = mag_s2;
	assign side_out  = side_s2;

endmodule

FILE: rtl/camera_pointing_yaw_pitch_core.sv
// An accepted request passes the input difference register, the yaw CORDIC chain, the gain stages and the pitch chain.
// Throughput: one request per cycle; busy is always low, the two CORDIC cell rows and the
// gain multipliers being fully pipelined.
// The receiver cannot stall: each result is shown for one cycle with done high.
// Reset clears only the valid pipeline; requests in flight at reset are dropped.
module camera_pointing_yaw_pitch_core #(
	parameter int CORDIC_STAGES = 24,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [30:0]                camera_lat,
	input  logic signed [31:0]                camera_lon,
	input  logic signed [39:0]                camera_alt,
	input  logic signed [30:0]                target_lat,
	input  logic signed [31:0]                target_lon,
	input  logic signed [39:0]                target_alt,
	output logic                              done,
	output logic signed [ANGLE_FRAC_BITS+8:0] yaw_angle,
	output logic signed [ANGLE_FRAC_BITS+7:0] pitch_angle
);
	import cpyp_pkg::*;

	localparam int YAW_W   = ANGLE_FRAC_BITS + 9;
	localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
	localparam int DZ_W    = 41;

	logic                       valid_s1;
	logic signed [32:0]         dx_s1;
	logic signed [31:0]         dy_s1;
	logic signed [DZ_W-1:0]     dz_s1;

	logic signed [XW_YAW-1:0]   yaw_x;
	logic signed [XW_YAW-1:0]   yaw_y;
	logic                       yaw_valid;
	logic signed [YAW_W-1:0]    yaw_out;
	logic signed [XW_YAW-1:0]   yaw_raw_x;
	logic [DZ_W-1:0]            yaw_dz;

	logic                       gain_valid;
	logic [XW_YAW-1:0]          gain_mag;
	logic [YAW_W-1:0]           gain_yaw;

	logic signed [XW_PITCH-1:0] pitch_x;
	logic signed [XW_PITCH-1:0] pitch_y;
	logic signed [XW_PITCH-1:0] pitch_raw_x;
	logic [YAW_W-1:0]           pitch_yaw;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 33'(target_lon) - 33'(camera_lon);
		dy_s1 <= 32'(target_lat) - 32'(camera_lat);
		dz_s1 <= DZ_W'(target_alt) - DZ_W'(camera_alt);
	end

	assign yaw_x = {(XW_YAW - GUARD_BITS)'(dx_s1), {GUARD_BITS{1'b0}}};
	assign yaw_y = {(XW_YAW - GUARD_BITS)'(dy_s1), {GUARD_BITS{1'b0}}};

	cpyp_cordic_chain #(
		.CORDIC_STAGES   (CORDIC_STAGES),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.XW              (XW_YAW),
		.SIDE_W          (DZ_W),
		.LIMIT_DEG       (180),
		.OUT_W           (YAW_W)
	) u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.x_in      (yaw_x),
		.y_in      (yaw_y),
		.side_in   (dz_s1),
		.out_valid (yaw_valid),
		.angle     (yaw_out),
		.raw_x     (yaw_raw_x),
		.side_out  (yaw_dz)
	);

	// The final yaw x is never negative, so it is scaled as an unsigned value.
	cpyp_gain #(
		.RW     (XW_YAW),
		.SIDE_W (YAW_W)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (yaw_valid),
		.raw_x     (yaw_raw_x),
		.side_in   (yaw_out),
		.out_valid (gain_valid),
		.mag       (gain_mag),
		.side_out  (gain_yaw)
	);

	logic [DZ_W-1:0] dz_d1;
	logic [DZ_W-1:0] dz_d2;

	// The altitude difference waits alongside the two gain stages.
	always_ff @(posedge clk) begin
		dz_d1 <= yaw_dz;
		dz_d2 <= dz_d1;
	end

	assign pitch_x = {{(XW_PITCH - XW_YAW){1'b0}}, gain_mag};
	assign pitch_y = {(XW_PITCH - GUARD_BITS)'($signed(dz_d2)), {GUARD_BITS{1'b0}}};

	cpyp_cordic_chain #(
		.CORDIC_STAGES   (CORDIC_STAGES),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.XW              (XW_PITCH),
		.SIDE_W          (YAW_W),
		.LIMIT_DEG       (90),
		.OUT_W           (PITCH_W)
	) u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gain_valid),
		.x_in      (pitch_x),
		.y_in      (pitch_y),
		.side_in   (gain_yaw),
		.out_valid (done),
		.angle     (pitch_angle),
		.raw_x     (pitch_raw_x),
		.side_out  (pitch_yaw)
	);

	assign yaw_angle = $signed(pitch_yaw);

endmodule
